/* sv/meab_pkg.sv */
`timescale 1ns / 1ps
// Package of the mesh edge adjacency builder: sizes, operation codes and state codes.
// It depends on nothing and is used by the builder unit, the checker and the bench.
package meab_pkg;

    localparam int EDGE_CAP  = 4096;
    localparam int FACE_CAP  = 4096;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int VTX_W     = 16;
    localparam int MAX_SIDES = 4;
    localparam int ENDS_W    = 2 * VTX_W;
    localparam int FACES_W   = 2 * IDX_W + 1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_CMT_RD,
        S_CMT_WR,
        S_RD_ISSUE,
        S_RD_EMIT
    } t_state;

    function automatic logic pair_match(input logic [ENDS_W-1:0] ends,
                                        input logic [VTX_W-1:0] a,
                                        input logic [VTX_W-1:0] b);
        logic [VTX_W-1:0] ea;
        logic [VTX_W-1:0] eb;
        ea = ends[VTX_W-1:0];
        eb = ends[ENDS_W-1:VTX_W];
        return ((ea == a) && (eb == b)) || ((ea == b) && (eb == a));
    endfunction

endpackage

/* sv/meab_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing.
module meab_ram #(
    parameter int W = 32,
    parameter int D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mesh_edge_adjacency_builder_unit.sv */
`timescale 1ns / 1ps
// Mesh edge adjacency builder: an add-face item is scanned against the edge table, one
// stored edge per cycle and face edge, and the search for a face edge stops early on a hit.
// The check state then tests capacity, and for each face edge the states S_CMT_RD and
// S_CMT_WR update the table, the latter waiting while the result output is stalled. A read
// passes S_RD_ISSUE and S_RD_EMIT; a clear is done in the idle state.
// Depends on meab_pkg and meab_ram; the edge endpoints and face links sit in two RAMs.
module mesh_edge_adjacency_builder_unit
    import meab_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [VTX_W-1:0]  i_vertex_0,
    input  logic [VTX_W-1:0]  i_vertex_1,
    input  logic [VTX_W-1:0]  i_vertex_2,
    input  logic [VTX_W-1:0]  i_vertex_3,
    input  logic [IDX_W-1:0]  i_edge_select,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [IDX_W-1:0]  o_edge_index,
    output logic [VTX_W-1:0]  o_end_a,
    output logic [VTX_W-1:0]  o_end_b,
    output logic [IDX_W-1:0]  o_first_face,
    output logic [IDX_W-1:0]  o_second_face,
    output logic              o_has_second_face,
    output logic              o_created,
    output logic              o_last,
    output logic              o_mesh_closed,
    output logic              o_table_full
);

    t_state            r_state, n_state;
    logic [1:0]        r_j, n_j;
    logic              r_n4, n_n4;
    logic [VTX_W-1:0]  r_v [MAX_SIDES];
    logic [VTX_W-1:0]  n_v [MAX_SIDES];
    logic [IDX_W-1:0]  r_sel, n_sel;
    logic [CNT_W-1:0]  r_addr, n_addr;
    logic              r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]  r_rd_addr, n_rd_addr;
    logic              r_hit [MAX_SIDES];
    logic              n_hit [MAX_SIDES];
    logic [IDX_W-1:0]  r_hidx [MAX_SIDES];
    logic [IDX_W-1:0]  n_hidx [MAX_SIDES];
    logic              r_dup [MAX_SIDES];
    logic              n_dup [MAX_SIDES];
    logic [1:0]        r_src [MAX_SIDES];
    logic [1:0]        n_src [MAX_SIDES];
    logic [IDX_W-1:0]  r_cidx [MAX_SIDES];
    logic [IDX_W-1:0]  n_cidx [MAX_SIDES];
    logic [CNT_W-1:0]  r_edge_cnt, n_edge_cnt;
    logic [CNT_W-1:0]  r_open_cnt, n_open_cnt;
    logic [CNT_W-1:0]  r_face_cnt, n_face_cnt;
    logic [2:0]        r_sides;

    logic              r_o_valid, n_o_valid;
    logic [IDX_W-1:0]  r_o_idx, n_o_idx;
    logic [VTX_W-1:0]  r_o_a, n_o_a;
    logic [VTX_W-1:0]  r_o_b, n_o_b;
    logic [IDX_W-1:0]  r_o_f1, n_o_f1;
    logic [IDX_W-1:0]  r_o_f2, n_o_f2;
    logic              r_o_hs, n_o_hs;
    logic              r_o_cr, n_o_cr;
    logic              r_o_last, n_o_last;
    logic              r_o_closed, n_o_closed;
    logic              r_o_full, n_o_full;

    logic [IDX_W-1:0]   raddr;
    logic               ends_we, faces_we;
    logic [IDX_W-1:0]   waddr;
    logic [ENDS_W-1:0]  ends_wdata, ends_rdata;
    logic [FACES_W-1:0] faces_wdata, faces_rdata;

    logic [VTX_W-1:0]  pa [MAX_SIDES];
    logic [VTX_W-1:0]  pb [MAX_SIDES];
    logic              used [MAX_SIDES];
    logic              miss [MAX_SIDES];
    logic              cdup [MAX_SIDES];
    logic [1:0]        csrc [MAX_SIDES];
    logic [2:0]        nnew;
    logic [1:0]        nm1;
    logic              can_emit;
    logic              reject;
    logic              scan_hit;
    logic [IDX_W-1:0]  target;
    logic              is_new;
    logic [IDX_W-1:0]  face_no;

    meab_ram #(.W(ENDS_W), .D(EDGE_CAP)) u_ends (
        .i_clk  (i_clk),
        .i_we   (ends_we),
        .i_waddr(waddr),
        .i_wdata(ends_wdata),
        .i_raddr(raddr),
        .o_rdata(ends_rdata)
    );

    meab_ram #(.W(FACES_W), .D(EDGE_CAP)) u_faces (
        .i_clk  (i_clk),
        .i_we   (faces_we),
        .i_waddr(waddr),
        .i_wdata(faces_wdata),
        .i_raddr(raddr),
        .o_rdata(faces_rdata)
    );

    assign nm1      = r_n4 ? 2'd3 : 2'd2;
    assign can_emit = !r_o_valid || !i_stall;
    assign face_no  = r_face_cnt[IDX_W-1:0];

    always_comb begin
        for (int j = 0; j < MAX_SIDES; j++) begin
            pa[j]   = r_v[j];
            used[j] = (2'(j) <= nm1);
        end
        pb[0] = r_v[1];
        pb[1] = r_v[2];
        pb[2] = r_n4 ? r_v[3] : r_v[0];
        pb[3] = r_v[0];
        nnew = 3'd0;
        for (int j = 0; j < MAX_SIDES; j++) begin
            miss[j] = used[j] && !r_hit[j];
            cdup[j] = 1'b0;
            csrc[j] = 2'd0;
            for (int m = MAX_SIDES - 1; m >= 0; m--) begin
                if ((m < j) && miss[j] && miss[m] &&
                    (((pa[m] == pa[j]) && (pb[m] == pb[j])) ||
                     ((pa[m] == pb[j]) && (pb[m] == pa[j])))) begin
                    cdup[j] = 1'b1;
                    csrc[j] = 2'(m);
                end
            end
            if (miss[j] && !cdup[j]) begin
                nnew = nnew + 3'd1;
            end
        end
        reject = (r_face_cnt >= CNT_W'(FACE_CAP)) ||
                 ({11'd0, nnew} > (14'(EDGE_CAP) - {1'b0, r_edge_cnt}));
    end

    assign scan_hit = r_rd_vld && pair_match(ends_rdata, pa[r_j], pb[r_j]);
    assign is_new   = !r_hit[r_j] && !r_dup[r_j];
    assign target   = r_hit[r_j] ? r_hidx[r_j] :
                      (r_dup[r_j] ? r_cidx[r_src[r_j]] : r_edge_cnt[IDX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_edge_cnt <= '0;
            r_open_cnt <= '0;
            r_face_cnt <= '0;
            r_sides    <= 3'd3;
            r_o_valid  <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_edge_cnt <= n_edge_cnt;
            r_open_cnt <= n_open_cnt;
            r_face_cnt <= n_face_cnt;
            r_o_valid  <= n_o_valid;
            r_rd_vld   <= n_rd_vld;
            if (i_cfg_we) begin
                r_sides <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_n4       <= n_n4;
        r_v        <= n_v;
        r_sel      <= n_sel;
        r_addr     <= n_addr;
        r_rd_addr  <= n_rd_addr;
        r_hit      <= n_hit;
        r_hidx     <= n_hidx;
        r_dup      <= n_dup;
        r_src      <= n_src;
        r_cidx     <= n_cidx;
        r_o_idx    <= n_o_idx;
        r_o_a      <= n_o_a;
        r_o_b      <= n_o_b;
        r_o_f1     <= n_o_f1;
        r_o_f2     <= n_o_f2;
        r_o_hs     <= n_o_hs;
        r_o_cr     <= n_o_cr;
        r_o_last   <= n_o_last;
        r_o_closed <= n_o_closed;
        r_o_full   <= n_o_full;
    end

    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        n_n4       = r_n4;
        n_v        = r_v;
        n_sel      = r_sel;
        n_addr     = r_addr;
        n_rd_vld   = 1'b0;
        n_rd_addr  = r_rd_addr;
        n_hit      = r_hit;
        n_hidx     = r_hidx;
        n_dup      = r_dup;
        n_src      = r_src;
        n_cidx     = r_cidx;
        n_edge_cnt = r_edge_cnt;
        n_open_cnt = r_open_cnt;
        n_face_cnt = r_face_cnt;
        n_o_valid  = r_o_valid && i_stall;
        n_o_idx    = r_o_idx;
        n_o_a      = r_o_a;
        n_o_b      = r_o_b;
        n_o_f1     = r_o_f1;
        n_o_f2     = r_o_f2;
        n_o_hs     = r_o_hs;
        n_o_cr     = r_o_cr;
        n_o_last   = r_o_last;
        n_o_closed = r_o_closed;
        n_o_full   = r_o_full;
        raddr       = r_sel;
        ends_we     = 1'b0;
        faces_we    = 1'b0;
        waddr       = target;
        ends_wdata  = {pb[r_j], pa[r_j]};
        faces_wdata = {1'b0, {IDX_W{1'b0}}, face_no};
        o_stall     = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_v[0] = i_vertex_0;
                    n_v[1] = i_vertex_1;
                    n_v[2] = i_vertex_2;
                    n_v[3] = i_vertex_3;
                    n_sel  = i_edge_select;
                    n_n4   = (r_sides >= 3'd4);
                    n_j    = 2'd0;
                    n_addr = '0;
                    for (int j = 0; j < MAX_SIDES; j++) begin
                        n_hit[j] = 1'b0;
                    end
                    unique case (t_opcode'(i_opcode))
                        OP_CLEAR: begin
                            n_edge_cnt = '0;
                            n_open_cnt = '0;
                            n_face_cnt = '0;
                        end
                        OP_ADD:  n_state = S_SCAN;
                        OP_READ: n_state = S_RD_ISSUE;
                        OP_NOP:  n_state = S_IDLE;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                raddr = r_addr[IDX_W-1:0];
                if (scan_hit || (r_addr >= r_edge_cnt)) begin
                    if (scan_hit) begin
                        n_hit[r_j]  = 1'b1;
                        n_hidx[r_j] = r_rd_addr;
                    end
                    n_addr = '0;
                    if (r_j == nm1) begin
                        n_state = S_CHECK;
                    end else begin
                        n_j = r_j + 2'd1;
                    end
                end else begin
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_addr[IDX_W-1:0];
                    n_addr    = r_addr + CNT_W'(1);
                end
            end
            S_CHECK: begin
                if (reject) begin
                    if (can_emit) begin
                        n_o_valid  = 1'b1;
                        n_o_idx    = '0;
                        n_o_a      = '0;
                        n_o_b      = '0;
                        n_o_f1     = '0;
                        n_o_f2     = '0;
                        n_o_hs     = 1'b0;
                        n_o_cr     = 1'b0;
                        n_o_last   = 1'b1;
                        n_o_closed = (r_open_cnt == '0);
                        n_o_full   = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_dup   = cdup;
                    n_src   = csrc;
                    n_j     = 2'd0;
                    n_state = S_CMT_RD;
                end
            end
            S_CMT_RD: begin
                raddr   = target;
                n_state = S_CMT_WR;
            end
            S_CMT_WR: begin
                raddr = target;
                if (can_emit) begin
                    n_o_valid = 1'b1;
                    n_o_idx   = target;
                    n_o_last  = (r_j == nm1);
                    n_o_full  = 1'b0;
                    faces_we  = 1'b1;
                    if (is_new) begin
                        ends_we         = 1'b1;
                        n_cidx[r_j]     = target;
                        n_edge_cnt      = r_edge_cnt + CNT_W'(1);
                        n_open_cnt      = r_open_cnt + CNT_W'(1);
                        n_o_a           = pa[r_j];
                        n_o_b           = pb[r_j];
                        n_o_f1          = face_no;
                        n_o_f2          = '0;
                        n_o_hs          = 1'b0;
                        n_o_cr          = 1'b1;
                    end else begin
                        faces_wdata = {1'b1, face_no, faces_rdata[IDX_W-1:0]};
                        if (!faces_rdata[FACES_W-1] && (r_open_cnt != '0)) begin
                            n_open_cnt = r_open_cnt - CNT_W'(1);
                        end
                        n_o_a  = ends_rdata[VTX_W-1:0];
                        n_o_b  = ends_rdata[ENDS_W-1:VTX_W];
                        n_o_f1 = faces_rdata[IDX_W-1:0];
                        n_o_f2 = face_no;
                        n_o_hs = 1'b1;
                        n_o_cr = 1'b0;
                    end
                    n_o_closed = (n_open_cnt == '0);
                    if (r_j == nm1) begin
                        n_face_cnt = r_face_cnt + CNT_W'(1);
                        n_state    = S_IDLE;
                    end else begin
                        n_j     = r_j + 2'd1;
                        n_state = S_CMT_RD;
                    end
                end
            end
            S_RD_ISSUE: begin
                n_state = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (can_emit) begin
                    n_o_valid  = 1'b1;
                    n_o_idx    = r_sel;
                    n_o_cr     = 1'b0;
                    n_o_last   = 1'b1;
                    n_o_closed = (r_open_cnt == '0);
                    n_o_full   = 1'b0;
                    if ({1'b0, r_sel} < r_edge_cnt) begin
                        n_o_a  = ends_rdata[VTX_W-1:0];
                        n_o_b  = ends_rdata[ENDS_W-1:VTX_W];
                        n_o_f1 = faces_rdata[IDX_W-1:0];
                        n_o_hs = faces_rdata[FACES_W-1];
                        n_o_f2 = faces_rdata[FACES_W-1] ?
                                 faces_rdata[2*IDX_W-1:IDX_W] : '0;
                    end else begin
                        n_o_a  = '0;
                        n_o_b  = '0;
                        n_o_f1 = '0;
                        n_o_f2 = '0;
                        n_o_hs = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid           = r_o_valid;
    assign o_edge_index      = r_o_idx;
    assign o_end_a           = r_o_a;
    assign o_end_b           = r_o_b;
    assign o_first_face      = r_o_f1;
    assign o_second_face     = r_o_f2;
    assign o_has_second_face = r_o_hs;
    assign o_created         = r_o_cr;
    assign o_last            = r_o_last;
    assign o_mesh_closed     = r_o_closed;
    assign o_table_full      = r_o_full;

endmodule

/* sv/meab_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the mesh edge adjacency builder, bound to the top level.
// Depends on meab_pkg.
module meab_checker
    import meab_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [IDX_W-1:0]  o_edge_index,
    input logic [IDX_W-1:0]  o_second_face,
    input logic              o_has_second_face,
    input logic              o_created,
    input logic              o_last,
    input logic              o_table_full
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_edge_index) && $stable(o_last))
        else $error("stalled result changed");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_table_full |-> o_last && !o_created && (o_edge_index == '0))
        else $error("rejected face result is malformed");

    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_created |-> !o_has_second_face && !o_table_full)
        else $error("new edge already has a second face");

    a_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_second_face |-> (o_second_face == '0))
        else $error("second face reported without valid flag");

endmodule

bind mesh_edge_adjacency_builder_unit meab_checker u_meab_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for mesh_edge_adjacency_builder_unit: a driver and a monitor in
// clocked always blocks, with an edge-table predictor that scores every result item.
// Depends on meab_pkg and the RTL of the block.
module tb_top;
    import meab_pkg::*;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [VTX_W-1:0] v0;
        logic [VTX_W-1:0] v1;
        logic [VTX_W-1:0] v2;
        logic [VTX_W-1:0] v3;
        logic [IDX_W-1:0] sel;
    } t_face_item;

    typedef struct packed {
        logic [IDX_W-1:0] edge_index;
        logic [VTX_W-1:0] end_a;
        logic [VTX_W-1:0] end_b;
        logic [IDX_W-1:0] first_face;
        logic [IDX_W-1:0] second_face;
        logic             has_second;
        logic             created;
        logic             last;
        logic             closed;
        logic             full;
    } t_edge_result;

    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic [1:0] i_opcode;
    logic [VTX_W-1:0] i_vertex_0, i_vertex_1, i_vertex_2, i_vertex_3;
    logic [IDX_W-1:0] i_edge_select;
    logic i_cfg_we;
    logic [2:0] i_cfg_data;
    logic o_valid;
    logic i_stall;
    logic [IDX_W-1:0] o_edge_index, o_first_face, o_second_face;
    logic [VTX_W-1:0] o_end_a, o_end_b;
    logic o_has_second_face, o_created, o_last, o_mesh_closed, o_table_full;

    mesh_edge_adjacency_builder_unit dut (.*);

    logic [VTX_W-1:0] ends_a [EDGE_CAP];
    logic [VTX_W-1:0] ends_b [EDGE_CAP];
    logic [IDX_W-1:0] face_first [EDGE_CAP];
    logic [IDX_W-1:0] face_second [EDGE_CAP];
    logic             face_paired [EDGE_CAP];
    int unsigned n_edges, n_open, n_faces, sides;

    t_face_item   pending_items[$];
    t_edge_result expected_edges[$];
    int unsigned  mismatches;
    int unsigned  cycles;
    int unsigned  send_gap;
    int unsigned  recv_gap;
    bit           hold_sender;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int find_pair(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b);
        for (int k = 0; k < n_edges; k++) begin
            if ((ends_a[k] == a && ends_b[k] == b) || (ends_a[k] == b && ends_b[k] == a))
                return k;
        end
        return -1;
    endfunction

    function automatic int unsigned short_or_long_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic queue_result(input t_edge_result r);
        expected_edges = {expected_edges, r};
    endtask

    task automatic queue_item(input t_face_item it);
        pending_items = {pending_items, it};
    endtask

    task automatic predict_edges(input t_face_item it);
        t_edge_result r;
        logic [VTX_W-1:0] v [4];
        logic [VTX_W-1:0] na [4];
        logic [VTX_W-1:0] nb [4];
        int unsigned fresh;
        int idx;
        bit seen;
        r = '0;
        case (it.opcode)
            OP_CLEAR: begin
                n_edges = 0;
                n_open = 0;
                n_faces = 0;
            end
            OP_READ: begin
                r.edge_index = it.sel;
                if (it.sel < n_edges) begin
                    r.end_a = ends_a[it.sel];
                    r.end_b = ends_b[it.sel];
                    r.first_face = face_first[it.sel];
                    r.has_second = face_paired[it.sel];
                    r.second_face = face_paired[it.sel] ? face_second[it.sel] : '0;
                end
                r.last = 1'b1;
                r.closed = (n_open == 0);
                queue_result(r);
            end
            OP_ADD: begin
                v[0] = it.v0;
                v[1] = it.v1;
                v[2] = it.v2;
                v[3] = it.v3;
                fresh = 0;
                for (int j = 0; j < sides; j++) begin
                    seen = (find_pair(v[j], v[(j + 1) % sides]) >= 0);
                    for (int m = 0; m < fresh; m++) begin
                        if ((na[m] == v[j] && nb[m] == v[(j + 1) % sides]) ||
                            (na[m] == v[(j + 1) % sides] && nb[m] == v[j]))
                            seen = 1;
                    end
                    if (!seen) begin
                        na[fresh] = v[j];
                        nb[fresh] = v[(j + 1) % sides];
                        fresh++;
                    end
                end
                if (n_faces >= FACE_CAP || fresh > EDGE_CAP - n_edges) begin
                    r.last = 1'b1;
                    r.full = 1'b1;
                    r.closed = (n_open == 0);
                    queue_result(r);
                end else begin
                    for (int j = 0; j < sides; j++) begin
                        r = '0;
                        idx = find_pair(v[j], v[(j + 1) % sides]);
                        if (idx >= 0) begin
                            if (!face_paired[idx] && n_open > 0) n_open--;
                            face_second[idx] = n_faces[IDX_W-1:0];
                            face_paired[idx] = 1'b1;
                        end else begin
                            idx = n_edges;
                            ends_a[idx] = v[j];
                            ends_b[idx] = v[(j + 1) % sides];
                            face_first[idx] = n_faces[IDX_W-1:0];
                            face_paired[idx] = 1'b0;
                            face_second[idx] = '0;
                            n_edges++;
                            n_open++;
                            r.created = 1'b1;
                        end
                        r.edge_index = idx[IDX_W-1:0];
                        r.end_a = ends_a[idx];
                        r.end_b = ends_b[idx];
                        r.first_face = face_first[idx];
                        r.has_second = face_paired[idx];
                        r.second_face = face_paired[idx] ? face_second[idx] : '0;
                        r.last = (j == sides - 1);
                        r.closed = (n_open == 0);
                        queue_result(r);
                    end
                    n_faces++;
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_face_item make_item(input logic [1:0] op, input int unsigned a,
                                             input int unsigned b, input int unsigned c,
                                             input int unsigned d, input int unsigned s);
        t_face_item it;
        it.opcode = op;
        it.v0 = a[VTX_W-1:0];
        it.v1 = b[VTX_W-1:0];
        it.v2 = c[VTX_W-1:0];
        it.v3 = d[VTX_W-1:0];
        it.sel = s[IDX_W-1:0];
        return it;
    endfunction

    function automatic t_face_item random_item(input int unsigned pool);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return make_item(OP_ADD, $urandom_range(0, pool), $urandom_range(0, pool),
                             $urandom_range(0, pool), $urandom_range(0, pool), 0);
        if (r < 82)
            return make_item(OP_READ, 0, 0, 0, 0, $urandom_range(0, 40));
        if (r < 90)
            return make_item(OP_READ, 0, 0, 0, 0, $urandom);
        if (r < 95)
            return make_item(OP_ADD, $urandom, $urandom, $urandom, $urandom, 0);
        if (r < 98)
            return make_item(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
        return make_item(OP_CLEAR, 0, 0, 0, 0, 0);
    endfunction

    task automatic drain_and_settle();
        while (pending_items.size() != 0 || expected_edges.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_sides(input int unsigned value);
        i_cfg_data <= value[2:0];
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sides = (value < 3) ? 3 : (value > MAX_SIDES) ? MAX_SIDES : value;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_valid && !o_stall) begin
            predict_edges({i_opcode, i_vertex_0, i_vertex_1, i_vertex_2, i_vertex_3,
                           i_edge_select});
            void'(pending_items.pop_front());
            send_gap <= short_or_long_gap();
            i_valid <= 1'b0;
        end else if (!i_valid && send_gap != 0) begin
            send_gap <= send_gap - 1;
        end else if (!i_valid && !hold_sender && pending_items.size() != 0) begin
            i_valid <= 1'b1;
            {i_opcode, i_vertex_0, i_vertex_1, i_vertex_2, i_vertex_3, i_edge_select}
                <= pending_items[0];
        end
    end

    always @(posedge i_clk) begin
        t_edge_result got;
        t_edge_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_edge_index, o_end_a, o_end_b, o_first_face, o_second_face,
                       o_has_second_face, o_created, o_last, o_mesh_closed, o_table_full};
                if (expected_edges.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result item %p", got);
                end else begin
                    want = expected_edges.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, actual %p", want, got);
                    end
                end
                recv_gap <= short_or_long_gap();
                i_stall <= 1'b1;
            end else if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned pool;
        n_edges = 0;
        n_open = 0;
        n_faces = 0;
        sides = 3;
        mismatches = 0;
        cycles = 0;
        hold_sender = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_opcode = OP_NOP;
        i_vertex_0 = '0;
        i_vertex_1 = '0;
        i_vertex_2 = '0;
        i_vertex_3 = '0;
        i_edge_select = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = 3'd3;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_item(make_item(OP_READ, 0, 0, 0, 0, 0));
        queue_item(make_item(OP_ADD, 0, 1, 2, 9, 0));
        queue_item(make_item(OP_ADD, 2, 1, 3, 9, 0));
        queue_item(make_item(OP_ADD, 0, 2, 1, 0, 0));
        queue_item(make_item(OP_ADD, 65535, 65535, 0, 0, 0));
        queue_item(make_item(OP_READ, 0, 0, 0, 0, 1));
        queue_item(make_item(OP_READ, 0, 0, 0, 0, 4095));
        queue_item(make_item(OP_NOP, 65535, 65535, 65535, 65535, 4095));
        queue_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
        queue_item(make_item(OP_READ, 0, 0, 0, 0, 0));
        queue_item(make_item(OP_ADD, 5, 5, 5, 5, 0));
        drain_and_settle();

        write_sides(4);
        queue_item(make_item(OP_ADD, 10, 11, 12, 13, 0));
        queue_item(make_item(OP_ADD, 10, 11, 10, 11, 0));
        queue_item(make_item(OP_ADD, 13, 12, 11, 10, 0));
        queue_item(make_item(OP_ADD, 65535, 0, 65535, 0, 0));
        queue_item(make_item(OP_READ, 0, 0, 0, 0, 2));
        drain_and_settle();

        for (int phase = 0; phase < 4; phase++) begin
            write_sides(phase == 0 ? 0 : phase == 1 ? 7 : phase == 2 ? 3 : 4);
            pool = (phase % 2) ? 6 : 20;
            for (int k = 0; k < 40; k++) begin
                queue_item(random_item(pool));
                if (phase == 1 && k == 20) begin
                    while (pending_items.size() != 0) @(posedge i_clk);
                    hold_sender = 1;
                    while (expected_edges.size() != 0) @(posedge i_clk);
                    hold_sender = 0;
                end
            end
            drain_and_settle();
        end

        if (mismatches == 0 && expected_edges.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* files.f */
sv/meab_pkg.sv
sv/meab_ram.sv
sv/mesh_edge_adjacency_builder_unit.sv
sv/meab_checker.sv
dv/tb_top.sv
